[design/ike_pkg.sv]
package ike_pkg;

  localparam int unsigned IN_W             = 20;
  localparam int unsigned OUT_W            = 56;
  localparam int unsigned GUARD_BITS       = 11;
  localparam int unsigned SQRT_CELLS       = 32;
  localparam int unsigned DEF_FRAC_BITS    = 8;
  localparam int unsigned DEF_CORDIC_STAGES = 24;
  localparam logic [55:0] LN2_Q56          = 56'hB17217F7D1CF7A;
  localparam logic [63:0] ONE_Q56          = 64'h0100_0000_0000_0000;
  localparam logic [IN_W-1:0] TOL_RESET    = 20'd1;

  typedef struct packed {
    logic [IN_W-1:0] mass;
    logic [IN_W-1:0] momentum;
  } ike_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] integral_value;
    logic             saturated;
  } ike_out_t;

  // one digit-recurrence square root step
  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } ike_sq_t;

  // hyperbolic vectoring state, all mod 2^64
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } ike_cord_t;

  typedef struct packed {
    logic [IN_W-1:0] m;
    logic [IN_W-1:0] p;
    logic [39:0]     m2;
    logic [39:0]     p2;
    logic            zf;
  } ike_sqs_t;

  typedef struct packed {
    logic [93:0] a;
    logic [79:0] zsum;
    logic [39:0] m2;
    logic [5:0]  e1;
    logic [5:0]  e2;
    logic        zf;
  } ike_cds_t;

  typedef struct packed {
    logic [93:0] a;
    logic [79:0] zsum;
    logic        zf;
  } ike_tail_t;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atanh_q56(input int unsigned i);
    logic [63:0] acc;
    acc = '0;
    for (int unsigned k = 1; i * k < 62; k += 2) begin
      acc = acc + udiv64(64'd1 << (62 - i * k), 64'(k));
    end
    return (acc + 64'd32) >> 6;
  endfunction

  function automatic int unsigned cordic_cells(input int unsigned stages);
    int unsigned n;
    n = stages;
    if (stages >= 4) n++;
    if (stages >= 13) n++;
    if (stages >= 40) n++;
    return n;
  endfunction

  // shift amount of cell idx; iterations 4, 13 and 40 run twice
  function automatic int unsigned cordic_shift(input int unsigned idx);
    int unsigned cnt;
    int unsigned res;
    cnt = 0;
    res = 1;
    for (int unsigned i = 1; i < 64; i++) begin
      if (cnt <= idx) res = i;
      cnt = cnt + ((i == 4 || i == 13 || i == 40) ? 2 : 1);
    end
    return res;
  endfunction

  function automatic logic [5:0] msb_index(input logic [32:0] x);
    logic [5:0] e;
    e = '0;
    for (int i = 0; i < 33; i++) begin
      if (x[i]) e = 6'(i);
    end
    return e;
  endfunction

endpackage

[design/integral_k2_times_energy.sv]
// The log chains have N cells, N = CORDIC_STAGES plus one per repeated iteration
// (4, 13, 40) that the stage count reaches.
// Throughput: one word per cycle; busy never rises and the result is not stalled.
// Length is set by the 32-cell square root chain and the N-cell log chains.
// Reset clears all pipeline valids and sets the tolerance register to 1.
module integral_k2_times_energy
  import ike_pkg::*;
#(
  parameter int unsigned INPUT_FRAC_BITS = DEF_FRAC_BITS,
  parameter int unsigned CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ike_in_t         in_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IN_W-1:0] cfg_data_i,
  output logic            res_strobe_o,
  output ike_out_t        res_o
);

  localparam int unsigned NC  = cordic_cells(CORDIC_STAGES);
  localparam int unsigned LAT = 43 + NC;
  localparam int unsigned RS  = 3 * INPUT_FRAC_BITS + GUARD_BITS + 3;
  localparam int unsigned ZS  = 3 * INPUT_FRAC_BITS + 2;

  logic            accept;
  logic [IN_W-1:0] tol_q;
  logic [LAT-1:0]  vld_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) tol_q <= cfg_data_i;
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // stage a
  logic [IN_W-1:0] ma_q, pa_q;
  logic            zfa_q;
  always_ff @(posedge clk_i) begin
    ma_q  <= in_i.mass;
    pa_q  <= in_i.momentum;
    zfa_q <= (in_i.mass == '0) || (in_i.mass < tol_q);
  end

  // stage b
  ike_sqs_t sb_q;
  always_ff @(posedge clk_i) begin
    sb_q.m  <= ma_q;
    sb_q.p  <= pa_q;
    sb_q.m2 <= 40'(ma_q) * 40'(ma_q);
    sb_q.p2 <= 40'(pa_q) * 40'(pa_q);
    sb_q.zf <= zfa_q;
  end

  // square root chain
  logic [40:0] msum;
  ike_sq_t     sq [SQRT_CELLS+1];
  ike_sqs_t    sqs_q [SQRT_CELLS];

  assign msum = 41'(sb_q.m2) + 41'(sb_q.p2);
  assign sq[0] = '{rem: '0, root: '0, rad: {1'b0, msum, 22'b0}};

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sq
    ike_sqrt_cell u_cell (.clk_i(clk_i), .d_i(sq[k]), .q_o(sq[k+1]));
  end

  always_ff @(posedge clk_i) begin
    sqs_q[0] <= sb_q;
    for (int k = 1; k < SQRT_CELLS; k++) sqs_q[k] <= sqs_q[k-1];
  end

  // stage d
  ike_sqs_t    sd;
  logic [31:0] root;
  logic [32:0] x1d_q, x2d_q;
  logic [51:0] pe_q;
  logic [41:0] s_q;
  logic [39:0] p2d_q, m2d_q;
  logic        zfd_q;

  assign sd   = sqs_q[SQRT_CELLS-1];
  assign root = sq[SQRT_CELLS].root;

  always_ff @(posedge clk_i) begin
    x1d_q <= 33'({sd.p, 11'b0}) + 33'(root);
    x2d_q <= 33'({sd.m, 11'b0});
    pe_q  <= 52'(sd.p) * 52'(root);
    s_q   <= 42'({sd.p2, 1'b0}) + 42'(sd.m2);
    p2d_q <= sd.p2;
    m2d_q <= sd.m2;
    zfd_q <= sd.zf;
  end

  // stage e
  logic [5:0]  e1e_q, e2e_q;
  logic [32:0] x1e_q, x2e_q;
  logic [46:0] aa_q [4];
  logic [39:0] zhh_q, zhl_q, zll_q;
  logic [39:0] m2e_q;
  logic        zfe_q;

  always_ff @(posedge clk_i) begin
    e1e_q <= msb_index(x1d_q);
    e2e_q <= msb_index(x2d_q);
    x1e_q <= x1d_q;
    x2e_q <= x2d_q;
    aa_q[0] <= 47'(pe_q[25:0]) * 47'(s_q[20:0]);
    aa_q[1] <= 47'(pe_q[25:0]) * 47'(s_q[41:21]);
    aa_q[2] <= 47'(pe_q[51:26]) * 47'(s_q[20:0]);
    aa_q[3] <= 47'(pe_q[51:26]) * 47'(s_q[41:21]);
    zhh_q <= 40'(p2d_q[39:20]) * 40'(p2d_q[39:20]);
    zhl_q <= 40'(p2d_q[39:20]) * 40'(p2d_q[19:0]);
    zll_q <= 40'(p2d_q[19:0]) * 40'(p2d_q[19:0]);
    m2e_q <= m2d_q;
    zfe_q <= zfd_q;
  end

  // stage f: normalize into [1,2) and seed the log chains
  logic [63:0] f1, f2;
  ike_cord_t   c1s_q, c2s_q;
  ike_cord_t   c1 [NC+1];
  ike_cord_t   c2 [NC+1];
  ike_cds_t    cf_q;
  ike_cds_t    cds_q [NC];

  assign f1 = 64'(x1e_q) << (7'd56 - 7'(e1e_q));
  assign f2 = 64'(x2e_q) << (7'd56 - 7'(e2e_q));

  always_ff @(posedge clk_i) begin
    c1s_q   <= '{x: f1 + ONE_Q56, y: f1 - ONE_Q56, z: '0};
    c2s_q   <= '{x: f2 + ONE_Q56, y: f2 - ONE_Q56, z: '0};
    cf_q.a  <= 94'(aa_q[0]) + (94'(aa_q[1]) << 21) + (94'(aa_q[2]) << 26)
             + (94'(aa_q[3]) << 47);
    cf_q.zsum <= (80'(zhh_q) << 40) + (80'(zhl_q) << 21) + 80'(zll_q);
    cf_q.m2 <= m2e_q;
    cf_q.e1 <= e1e_q;
    cf_q.e2 <= e2e_q;
    cf_q.zf <= zfe_q;
  end

  assign c1[0] = c1s_q;
  assign c2[0] = c2s_q;

  for (genvar j = 0; j < NC; j++) begin : g_cord
    ike_cordic_cell #(.SHIFT(cordic_shift(j))) u_c1 (
      .clk_i(clk_i), .d_i(c1[j]), .q_o(c1[j+1])
    );
    ike_cordic_cell #(.SHIFT(cordic_shift(j))) u_c2 (
      .clk_i(clk_i), .d_i(c2[j]), .q_o(c2[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    cds_q[0] <= cf_q;
    for (int k = 1; k < NC; k++) cds_q[k] <= cds_q[k-1];
  end

  // stage g: ln = e*ln2 + 2z
  ike_cds_t    cg;
  logic [63:0] ln1_q, ln2_q;
  logic [39:0] mhh_q, mhl_q, mll_q;
  ike_tail_t   tg_q;

  assign cg = cds_q[NC-1];

  always_ff @(posedge clk_i) begin
    ln1_q <= 64'(62'(cg.e1) * 62'(LN2_Q56)) + {c1[NC].z[62:0], 1'b0};
    ln2_q <= 64'(62'(cg.e2) * 62'(LN2_Q56)) + {c2[NC].z[62:0], 1'b0};
    mhh_q <= 40'(cg.m2[39:20]) * 40'(cg.m2[39:20]);
    mhl_q <= 40'(cg.m2[39:20]) * 40'(cg.m2[19:0]);
    mll_q <= 40'(cg.m2[19:0]) * 40'(cg.m2[19:0]);
    tg_q  <= '{a: cg.a, zsum: cg.zsum, zf: cg.zf};
  end

  // stage h
  logic [63:0] dl;
  logic [44:0] l40_q;
  logic [79:0] mm_q;
  ike_tail_t   th_q;

  assign dl = ln1_q - ln2_q;

  always_ff @(posedge clk_i) begin
    l40_q <= (!dl[63] && dl != '0) ? dl[60:16] : '0;
    mm_q  <= (80'(mhh_q) << 40) + (80'(mhl_q) << 21) + 80'(mll_q);
    th_q  <= tg_q;
  end

  // stage i
  logic [42:0] pl_q [4];
  logic [42:0] ph_q [4];
  ike_tail_t   ti_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      pl_q[c] <= 43'(mm_q[20*c +: 20]) * 43'(l40_q[22:0]);
      ph_q[c] <= 43'(mm_q[20*c +: 20]) * 43'(l40_q[44:23]);
    end
    ti_q <= th_q;
  end

  // stage j
  logic [65:0] qs_q [4];
  ike_tail_t   tj_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      qs_q[c] <= 66'(pl_q[c]) + (66'(ph_q[c]) << 23);
    end
    tj_q <= ti_q;
  end

  // stage k
  logic [125:0] prod;
  logic [96:0]  b_q;
  ike_tail_t    tk_q;

  assign prod = 126'(qs_q[0]) + (126'(qs_q[1]) << 20) + (126'(qs_q[2]) << 40)
              + (126'(qs_q[3]) << 60);

  always_ff @(posedge clk_i) begin
    b_q  <= prod[125:29];
    tk_q <= tj_q;
  end

  // stage l
  logic [96:0] a97, tdiff, tres;
  logic [79:0] zres;
  ike_out_t    out_q;

  assign a97   = 97'(tk_q.a);
  assign tdiff = (a97 > b_q) ? (a97 - b_q) : '0;
  assign tres  = tdiff >> RS;
  assign zres  = tk_q.zsum >> ZS;

  always_ff @(posedge clk_i) begin
    if (tk_q.zf) begin
      out_q.saturated      <= |zres[79:OUT_W];
      out_q.integral_value <= (|zres[79:OUT_W]) ? '1 : zres[OUT_W-1:0];
    end else begin
      out_q.saturated      <= |tres[96:OUT_W];
      out_q.integral_value <= (|tres[96:OUT_W]) ? '1 : tres[OUT_W-1:0];
    end
  end

  assign res_strobe_o = vld_q[LAT-1];
  assign res_o        = out_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LAT) res_strobe_o)
    else $error("accepted word did not produce a result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start, LAT))
    else $error("result without a matching start");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.saturated |-> &res_o.integral_value)
    else $error("saturated result not at full scale");
`endif

endmodule

[design/ike_sqrt_cell.sv]
module ike_sqrt_cell
  import ike_pkg::*;
(
  input  logic    clk_i,
  input  ike_sq_t d_i,
  output ike_sq_t q_o
);

  logic [34:0] t;
  logic [34:0] trial;
  ike_sq_t     q_d;
  ike_sq_t     q_q;

  assign t     = {d_i.rem, d_i.rad[63:62]};
  assign trial = {1'b0, d_i.root, 2'b01};

  always_comb begin
    q_d.rad = {d_i.rad[61:0], 2'b00};
    if (t >= trial) begin
      q_d.rem  = 33'(t - trial);
      q_d.root = {d_i.root[30:0], 1'b1};
    end else begin
      q_d.rem  = t[32:0];
      q_d.root = {d_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

[design/ike_cordic_cell.sv]
module ike_cordic_cell
  import ike_pkg::*;
#(
  parameter int unsigned SHIFT = 1
) (
  input  logic      clk_i,
  input  ike_cord_t d_i,
  output ike_cord_t q_o
);

  localparam logic [63:0] ANGLE = atanh_q56(SHIFT);

  ike_cord_t q_d;
  ike_cord_t q_q;

  always_comb begin
    if (!d_i.y[63]) begin
      q_d.x = d_i.x - (d_i.y >> SHIFT);
      q_d.y = d_i.y - (d_i.x >> SHIFT);
      q_d.z = d_i.z + ANGLE;
    end else begin
      q_d.x = d_i.x + 64'($signed(d_i.y) >>> SHIFT);
      q_d.y = d_i.y + (d_i.x >> SHIFT);
      q_d.z = d_i.z - ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule
